// ===== design/tfn_pkg.sv =====
// Package for the triangle face normal block: widths and shared types.
// No dependencies.
package tfn_pkg;

  localparam int CoordWidth = 32;
  localparam int NormFracBits = 14;
  localparam int NormWidth = NormFracBits + 2;
  localparam int DiffWidth = CoordWidth + 1;
  localparam int ProdWidth = 2 * DiffWidth;
  localparam int CrossWidth = ProdWidth + 1;
  localparam int MagWidth = CrossWidth;
  localparam int BitLenWidth = $clog2(MagWidth + 1);
  localparam int QueueDepth = 2;
  localparam int QueueIdxWidth = $clog2(QueueDepth);

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  // One triangle handed from the front to the back.
  typedef struct packed {
    vertex_t v0;
    vertex_t v1;
    vertex_t v2;
  } tri_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic signed [NormWidth-1:0] norm_x;
    logic signed [NormWidth-1:0] norm_y;
    logic signed [NormWidth-1:0] norm_z;
    logic degenerate;
    logic last;
  } result_t;

endpackage

// ===== design/tfn_if.sv =====
// Valid/ready channel interfaces for vertices and results.
// Depends on tfn_pkg.
interface tfn_vertex_if;
  import tfn_pkg::*;
  logic valid;
  logic ready;
  coord_t in_x;
  coord_t in_y;
  coord_t in_z;
  modport source(output valid, in_x, in_y, in_z, input ready);
  modport sink(input valid, in_x, in_y, in_z, output ready);
endinterface

interface tfn_result_if;
  import tfn_pkg::*;
  logic valid;
  logic ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  logic signed [NormWidth-1:0] norm_x;
  logic signed [NormWidth-1:0] norm_y;
  logic signed [NormWidth-1:0] norm_z;
  logic degenerate;
  logic last;
  modport source(output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                 degenerate, last, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
               degenerate, last, output ready);
endinterface

// ===== design/tfn_front.sv =====
// Front end: collects vertices into triangles and pushes them into a queue.
// Depends on tfn_pkg and tfn_if.
module tfn_front (
  input  logic clk,
  input  logic rst,
  tfn_vertex_if.sink vin,
  output logic tri_valid,
  input  logic tri_ready,
  output tfn_pkg::tri_t tri_data
);
  import tfn_pkg::*;

  vertex_t held [2];
  logic [1:0] vertex_count;
  tri_t queue [QueueDepth];
  logic [QueueIdxWidth-1:0] wr_ptr, rd_ptr;
  logic [QueueIdxWidth:0] fill;
  logic accept, push, pop;
  vertex_t cur;

  assign cur = '{x: vin.in_x, y: vin.in_y, z: vin.in_z};
  // The first two vertices only need storage; the third needs a queue slot.
  assign vin.ready = (vertex_count != 2'd2) || (fill != QueueDepth[QueueIdxWidth:0]);
  assign accept = vin.valid && vin.ready;
  assign push = accept && (vertex_count == 2'd2);
  assign tri_valid = (fill != '0);
  assign pop = tri_valid && tri_ready;
  assign tri_data = queue[rd_ptr];

  // Vertex gathering.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 2'd0;
    end else if (accept) begin
      vertex_count <= (vertex_count == 2'd2) ? 2'd0 : vertex_count + 2'd1;
    end
    if (accept && vertex_count != 2'd2) begin
      held[vertex_count[0]] <= cur;
    end
  end

  // Triangle queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + {{QueueIdxWidth{1'b0}}, push} - {{QueueIdxWidth{1'b0}}, pop};
    end
    if (push) begin
      queue[wr_ptr] <= '{v0: held[0], v1: held[1], v2: cur};
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QueueDepth[QueueIdxWidth:0]) else $error("queue overfilled");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    vertex_count != 2'd3) else $error("bad vertex count");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (fill != QueueDepth[QueueIdxWidth:0] || pop) || fill != QueueDepth[QueueIdxWidth:0])
    else $error("push into full queue");
endmodule

// ===== design/tfn_back.sv =====
// Back end: computes the face normal with shared multiplier, square root and
// divider steps, then emits the three vertices. Depends on tfn_pkg and tfn_if.
module tfn_back (
  input  logic clk,
  input  logic rst,
  input  logic tri_valid,
  output logic tri_ready,
  input  tfn_pkg::tri_t tri_data,
  tfn_result_if.source rout
);
  import tfn_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_CROSS = 9'b000000100,
    S_LEN   = 9'b000001000,
    S_NORM  = 9'b000010000,
    S_SQ    = 9'b000100000,
    S_SQRT  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state;
  tri_t tri_r;
  logic signed [DiffWidth-1:0] d1 [3];
  logic signed [DiffWidth-1:0] d0 [3];
  logic signed [ProdWidth-1:0] prod [6];
  logic [MagWidth-1:0] mag [3];
  logic neg [3];
  logic [BitLenWidth-1:0] mlen;
  logic [30:0] a [3];
  logic [63:0] s_sum, sq_rem, sq_res;
  logic [5:0] step;
  logic [1:0] comp;
  logic [NormWidth-1:0] q [3];
  logic degen;
  logic [1:0] emit_idx;
  logic [46:0] div_rem;
  logic [NormFracBits+31:0] div_num;
  logic [NormFracBits+1:0] div_q;

  logic signed [DiffWidth-1:0] mul_a, mul_b;
  logic signed [ProdWidth-1:0] mul_p;
  logic [2:0] mul_i;
  logic [MagWidth-1:0] len_max;
  logic [BitLenWidth-1:0] len_bits;
  logic [61:0] sq_term;
  logic [63:0] sq_try;
  logic [47:0] div_try;
  logic [NormFracBits+1:0] q_sat;
  logic signed [CrossWidth-1:0] cross_c [3];

  // Operands for the six cross products, one per cycle (33 x 33 bits).
  always_comb begin
    case (mul_i)
      3'd0: begin mul_a = d1[1]; mul_b = d0[2]; end
      3'd1: begin mul_a = d1[2]; mul_b = d0[1]; end
      3'd2: begin mul_a = d1[2]; mul_b = d0[0]; end
      3'd3: begin mul_a = d1[0]; mul_b = d0[2]; end
      3'd4: begin mul_a = d1[0]; mul_b = d0[1]; end
      default: begin mul_a = d1[1]; mul_b = d0[0]; end
    endcase
    mul_p = mul_a * mul_b;
  end
  assign mul_i = step[2:0];

  // Cross components, their magnitudes and the bit length of the largest one.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cross_c[i] = CrossWidth'(prod[2*i]) - CrossWidth'(prod[2*i+1]);
    end
    len_max = mag[0] | mag[1] | mag[2];
    len_bits = '0;
    for (int b = 0; b < MagWidth; b++) begin
      if (len_max[b]) len_bits = BitLenWidth'(b + 1);
    end
  end

  // Square of one normalized component (31 x 31 bits).
  assign sq_term = a[comp] * a[comp];

  // Restoring square root trial and divider trial.
  assign sq_try = sq_res | (64'd1 << {step[4:0], 1'b0});
  assign div_try = {div_rem, div_num[NormFracBits+31]} - {16'd0, sq_res[31:0]};
  assign q_sat = (div_q > (NormWidth'(1) << NormFracBits)) ?
                 (NormWidth'(1) << NormFracBits) : div_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      emit_idx <= '0;
      comp <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (tri_valid) begin
            tri_r <= tri_data;
            d1[0] <= DiffWidth'(tri_data.v1.x) - DiffWidth'(tri_data.v2.x);
            d1[1] <= DiffWidth'(tri_data.v1.y) - DiffWidth'(tri_data.v2.y);
            d1[2] <= DiffWidth'(tri_data.v1.z) - DiffWidth'(tri_data.v2.z);
            d0[0] <= DiffWidth'(tri_data.v0.x) - DiffWidth'(tri_data.v2.x);
            d0[1] <= DiffWidth'(tri_data.v0.y) - DiffWidth'(tri_data.v2.y);
            d0[2] <= DiffWidth'(tri_data.v0.z) - DiffWidth'(tri_data.v2.z);
            step <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod[mul_i] <= mul_p;
          step <= step + 6'd1;
          if (mul_i == 3'd5) state <= S_CROSS;
        end
        S_CROSS: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= cross_c[i][CrossWidth-1];
            mag[i] <= cross_c[i][CrossWidth-1] ? MagWidth'(-cross_c[i]) : MagWidth'(cross_c[i]);
          end
          state <= S_LEN;
        end
        S_LEN: begin
          mlen <= len_bits;
          state <= S_NORM;
        end
        S_NORM: begin
          degen <= (mlen == '0);
          for (int i = 0; i < 3; i++) begin
            if (mlen > BitLenWidth'(31))
              a[i] <= 31'(mag[i] >> (mlen - BitLenWidth'(31)));
            else
              a[i] <= 31'(mag[i] << (BitLenWidth'(31) - mlen));
          end
          s_sum <= '0;
          comp <= '0;
          state <= (mlen == '0) ? S_EMIT : S_SQ;
          emit_idx <= '0;
          for (int i = 0; i < 3; i++) q[i] <= '0;
        end
        S_SQ: begin
          s_sum <= s_sum + 64'(sq_term);
          if (comp == 2'd2) begin
            state <= S_SQRT;
            step <= 6'd31;
            sq_res <= '0;
            sq_rem <= s_sum + 64'(sq_term);
            comp <= '0;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        S_SQRT: begin
          // One result bit per cycle; sq_res keeps root bits aligned at 2*step.
          if (sq_rem >= sq_try) begin
            sq_rem <= sq_rem - sq_try;
            sq_res <= (sq_res >> 1) | (64'd1 << {step[4:0], 1'b0});
          end else begin
            sq_res <= sq_res >> 1;
          end
          if (step == 6'd0) begin
            state <= S_DIV;
            step <= 6'(NormFracBits + 32);
            div_rem <= '0;
            div_q <= '0;
            div_num <= ({15'd0, a[0]} << NormFracBits) + 46'(sq_try[32:1] >> 1);
          end else begin
            step <= step - 6'd1;
          end
        end
        S_DIV: begin
          if (step == '0) begin
            q[comp] <= neg[comp] ? NormWidth'(-q_sat) : NormWidth'(q_sat);
            comp <= comp + 2'd1;
            step <= 6'(NormFracBits + 32);
            div_rem <= '0;
            div_q <= '0;
            div_num <= ({15'd0, a[comp + 2'd1]} << NormFracBits) + 46'(sq_res[31:1]);
            if (comp == 2'd2) state <= S_EMIT;
          end else begin
            if (!div_try[47]) begin
              div_rem <= div_try[46:0];
              div_q <= {div_q[NormFracBits:0], 1'b1} | ((div_q >> NormFracBits) != '0 ?
                       {(NormFracBits+2){1'b1}} : '0);
            end else begin
              div_rem <= {div_rem[45:0], div_num[NormFracBits+31]};
              div_q <= {div_q[NormFracBits:0], 1'b0} | ((div_q >> NormFracBits) != '0 ?
                       {(NormFracBits+2){1'b1}} : '0);
            end
            div_num <= {div_num[NormFracBits+30:0], 1'b0};
            step <= step - 6'd1;
          end
        end
        S_EMIT: begin
          if (rout.ready) begin
            if (emit_idx == 2'd2) begin
              emit_idx <= '0;
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign tri_ready = (state == S_IDLE);

  // Result mux.
  always_comb begin
    vertex_t v;
    case (emit_idx)
      2'd0: v = tri_r.v0;
      2'd1: v = tri_r.v1;
      default: v = tri_r.v2;
    endcase
    rout.valid = (state == S_EMIT);
    rout.pos_x = v.x;
    rout.pos_y = v.y;
    rout.pos_z = v.z;
    rout.norm_x = q[0];
    rout.norm_y = q[1];
    rout.norm_z = q[2];
    rout.degenerate = degen;
    rout.last = (emit_idx == 2'd2);
  end

  a_emit_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> emit_idx != 2'd3) else $error("emit index out of range");
  a_last_leaves: assert property (@(posedge clk) disable iff (rst)
    (rout.valid && rout.ready && rout.last) |=> state == S_IDLE)
    else $error("last result did not end the triangle");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (rout.valid && rout.degenerate) |-> (rout.norm_x == '0 && rout.norm_y == '0
    && rout.norm_z == '0)) else $error("degenerate with nonzero normal");
endmodule

// ===== design/triangle_face_normal_interleaver.sv =====
// Triangle face normal interleaver. Vertices (signed Q16.16) are accepted
// whenever the front end has storage; each third vertex completes a triangle,
// which goes into a two-entry queue. The back end takes one triangle at a time:
// 33x33 cross products on one shared multiplier, normalization, then (unless the
// triangle is degenerate) a sum of squares, a bit-serial square root and three
// serial divides, after which its three results are offered in turn, held while
// the receiver stalls, each with the Q1.14 face normal and a last flag.
// Depends on tfn_pkg, tfn_if, tfn_front and tfn_back.
module triangle_face_normal_interleaver (
  input logic clk,
  input logic rst,
  tfn_vertex_if.sink vin,
  tfn_result_if.source rout
);
  import tfn_pkg::*;

  logic tri_valid;
  logic tri_ready;
  tri_t tri_data;

  tfn_front u_front (
    .clk(clk), .rst(rst), .vin(vin),
    .tri_valid(tri_valid), .tri_ready(tri_ready), .tri_data(tri_data)
  );

  tfn_back u_back (
    .clk(clk), .rst(rst),
    .tri_valid(tri_valid), .tri_ready(tri_ready), .tri_data(tri_data),
    .rout(rout)
  );
endmodule

// ===== tb/tfn_tb_if.sv =====
// Testbench package: the record of one expected result transaction.
// Depends on tfn_pkg.
package tfn_tb_pkg;
  import tfn_pkg::*;

  // Expected result as predicted for one emitted vertex.
  typedef struct {
    coord_t px;
    coord_t py;
    coord_t pz;
    logic signed [NormWidth-1:0] nx;
    logic signed [NormWidth-1:0] ny;
    logic signed [NormWidth-1:0] nz;
    logic degen;
    logic last;
  } vtx_result_t;
endpackage

// ===== tb/triangle_face_normal_interleaver_tb.sv =====
// Testbench for the triangle face normal interleaver: random and directed vertex streams,
// predicted normals compared with every result transaction. Depends on tfn_pkg, tfn_if,
// tfn_tb_pkg and the block itself.
module triangle_face_normal_interleaver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tfn_pkg::*;
  import tfn_tb_pkg::*;

  // Predicts face normals and holds the results still to come.
  class normal_scoreboard;
    coord_t held[2][3];
    int vcount;
    vtx_result_t pending[$];
    int mismatches;

    function void reset_state();
      vcount = 0;
      pending.delete();
      mismatches = 0;
    endfunction

    // Unsigned integer square root by the bitwise method.
    function longint unsigned root64(longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
        if (s >= res + bitv) begin
          s -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Notes one accepted vertex; the third completes a triangle.
    function void note_vertex(coord_t x, coord_t y, coord_t z);
      logic signed [DiffWidth-1:0] d1[3], d0[3];
      logic signed [CrossWidth-1:0] cr[3];
      logic [CrossWidth-1:0] mag[3];
      longint unsigned a[3], s, r, q;
      logic signed [NormWidth-1:0] nrm[3];
      coord_t v[3][3];
      int msb, sh;
      logic degen;
      vtx_result_t e;
      if (vcount < 2) begin
        held[vcount] = '{x, y, z};
        vcount++;
        return;
      end
      v[0] = held[0];
      v[1] = held[1];
      v[2] = '{x, y, z};
      for (int i = 0; i < 3; i++) begin
        d1[i] = DiffWidth'(v[1][i]) - DiffWidth'(v[2][i]);
        d0[i] = DiffWidth'(v[0][i]) - DiffWidth'(v[2][i]);
      end
      cr[0] = CrossWidth'(d1[1] * d0[2]) - CrossWidth'(d1[2] * d0[1]);
      cr[1] = CrossWidth'(d1[2] * d0[0]) - CrossWidth'(d1[0] * d0[2]);
      cr[2] = CrossWidth'(d1[0] * d0[1]) - CrossWidth'(d1[1] * d0[0]);
      msb = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
        for (int b = 0; b < CrossWidth; b++) if (mag[i][b] && b + 1 > msb) msb = b + 1;
      end
      degen = (msb == 0);
      s = 0;
      for (int i = 0; i < 3; i++) begin
        if (msb > 31) a[i] = 64'(mag[i] >> (msb - 31));
        else a[i] = 64'(mag[i]) << (31 - msb);
        a[i] &= 64'h7FFF_FFFF;
        s += a[i] * a[i];
      end
      r = degen ? 1 : root64(s);
      for (int i = 0; i < 3; i++) begin
        if (degen) begin
          nrm[i] = '0;
        end else begin
          q = ((a[i] << NormFracBits) + (r >> 1)) / r;
          if (q > (64'd1 << NormFracBits)) q = 64'd1 << NormFracBits;
          nrm[i] = cr[i] < 0 ? -NormWidth'(q) : NormWidth'(q);
        end
      end
      for (int k = 0; k < 3; k++) begin
        e.px = v[k][0];
        e.py = v[k][1];
        e.pz = v[k][2];
        e.nx = nrm[0];
        e.ny = nrm[1];
        e.nz = nrm[2];
        e.degen = degen;
        e.last = (k == 2);
        pending.insert(pending.size(), e);
      end
      vcount = 0;
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(vtx_result_t got);
      vtx_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.px !== e.px || got.py !== e.py || got.pz !== e.pz || got.nx !== e.nx ||
          got.ny !== e.ny || got.nz !== e.nz || got.degen !== e.degen ||
          got.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  tfn_vertex_if vin();
  tfn_result_if rout();
  normal_scoreboard sb = new();
  longint cycles = 0;
  int stall_long = 0;
  bit stim_done = 1'b0;

  triangle_face_normal_interleaver i_dut (.clk(clk), .rst(rst), .vin(vin), .rout(rout));

  always #10 clk = ~clk;

  initial begin
    vin.valid = 1'b0;
    vin.in_x = '0;
    vin.in_y = '0;
    vin.in_z = '0;
    rout.ready = 1'b0;
    sb.reset_state();
  end

  // Note accepted vertices and check result transactions.
  always @(posedge clk) begin
    vtx_result_t got;
    cycles <= cycles + 1;
    if (!rst && vin.valid && vin.ready) sb.note_vertex(vin.in_x, vin.in_y, vin.in_z);
    if (!rst && rout.valid && rout.ready) begin
      got = '{rout.pos_x, rout.pos_y, rout.pos_z, rout.norm_x, rout.norm_y, rout.norm_z,
              rout.degenerate, rout.last};
      sb.check_result(got);
    end
  end

  // Receiver: random stalls per transaction, plus one long hold-off.
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_long > 0) begin
        rout.ready <= 1'b0;
        stall_long--;
        @(posedge clk);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        rout.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        rout.ready <= 1'b1;
        @(posedge clk);
        while (!rout.valid && stall_long == 0) @(posedge clk);
      end
    end
  end

  // Offers one vertex and waits for its acceptance, after a random gap unless burst is set.
  task automatic send_vertex(coord_t x, coord_t y, coord_t z, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      vin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vin.valid <= 1'b1;
    vin.in_x <= x;
    vin.in_y <= y;
    vin.in_z <= z;
    @(posedge clk);
    while (!vin.ready) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return coord_t'($signed($urandom_range(0, 200000)) - 100000) <<< 8;
    endcase
  endfunction

  // Stimulus: directed triangles, then random ones.
  initial begin
    coord_t mx, mn;
    int mode;
    bit burst;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Unit triangle in the xy plane, degenerate ones, extreme and negative coordinates.
    send_vertex(0, 0, 0, 0);
    send_vertex(32'sh10000, 0, 0, 0);
    send_vertex(0, 32'sh10000, 0, 0);
    send_vertex(5, 5, 5, 0);
    send_vertex(5, 5, 5, 0);
    send_vertex(5, 5, 5, 0);
    send_vertex(mx, mx, mx, 0);
    send_vertex(mn, mn, mn, 0);
    send_vertex(mx, mn, mx, 0);
    send_vertex(mn, mx, 0, 0);
    send_vertex(mx, 0, mn, 0);
    send_vertex(0, mn, mx, 0);
    send_vertex(1, 2, 3, 0);
    send_vertex(2, 4, 6, 0);
    send_vertex(3, 6, 9, 0);
    send_vertex(-1, 0, 0, 0);
    send_vertex(0, -1, 0, 0);
    send_vertex(0, 0, -1, 0);
    // Hold the receiver off while vertices keep coming so the block fills.
    stall_long = 2000;
    for (int i = 0; i < 500; i++) begin
      mode = $urandom_range(0, 3);
      burst = (i % 60) < 12;
      if ($urandom_range(0, 20) == 0) begin
        mx = rand_coord(mode);
        send_vertex(mx, rand_coord(mode), rand_coord(mode), burst);
      end else begin
        send_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode), burst);
      end
    end
    vin.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // End of run: drain, then report.
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0 && cycles < 2_000_000) @(posedge clk);
    repeat (500) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("triangle_face_normal_interleaver_tb: clean");
    end else begin
      $display("triangle_face_normal_interleaver_tb: errors");
    end
    $finish;
  end

  // Watchdog on a cycle count.
  initial begin
    wait (cycles >= 2_000_000);
    $display("triangle_face_normal_interleaver_tb: errors");
    $finish;
  end
endmodule
